/* sv/assert_macros.svh */
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check that a property holds at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Check that a condition never holds outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

/* sv/acor_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package acor_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 32;
  localparam int HW_W    = 48;
  localparam int STAMP_W = 64;

  // One stored mapping as it sits in the entry memory
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [HW_W-1:0]    hw;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Lookup result handed from the scanner to the output register
  typedef struct packed {
    logic            found;
    logic [HW_W-1:0] hw;
  } res_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

/* sv/acor_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module acor_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* sv/acor_scan.sv */
`timescale 1ns / 1ps
`default_nettype none
module acor_scan (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            action,
  input  wire logic [acor_pkg::KEY_W-1:0]      proto_addr,
  input  wire logic [acor_pkg::HW_W-1:0]       new_hw_addr,
  input  wire logic [acor_pkg::STAMP_W-1:0]    now,
  output logic                                 res_valid,
  input  wire logic                            res_ready,
  output acor_pkg::res_t                       res,
  output logic                                 ram_we,
  output logic      [acor_pkg::IDX_W-1:0]      ram_waddr,
  output logic      [acor_pkg::ENTRY_W-1:0]    ram_wdata,
  output logic                                 ram_re,
  output logic      [acor_pkg::IDX_W-1:0]      ram_raddr,
  input  wire logic [acor_pkg::ENTRY_W-1:0]    ram_rdata
);

  import acor_pkg::*;

  state_t             state, state_next;
  logic [ENTRIES-1:0] valid;
  logic [CNT_W-1:0]   issue_cnt;
  logic               rd_pend;
  logic [IDX_W-1:0]   rd_idx;

  // Latched request
  logic               req_action;
  logic [KEY_W-1:0]   req_key;
  logic [HW_W-1:0]    req_hw;
  logic [STAMP_W-1:0] req_now;

  // Scan results
  logic               hit;
  logic [IDX_W-1:0]   hit_idx;
  logic [HW_W-1:0]    hit_hw;
  logic               free_seen;
  logic [IDX_W-1:0]   free_idx;
  logic               old_seen;
  logic [IDX_W-1:0]   old_idx;
  logic [STAMP_W-1:0] old_stamp;

  logic               accept;
  logic               rd_en;
  entry_t             rd_entry;
  logic               rd_valid;
  logic               rd_match;
  logic               rd_older;
  logic [IDX_W-1:0]   slot;
  entry_t             wr_entry;

  // Decode the entry coming back from memory
  always_comb begin
    rd_entry = entry_t'(ram_rdata);
    rd_valid = valid[rd_idx];
    rd_match = rd_valid && (rd_entry.key == req_key);
    rd_older = rd_valid && (!old_seen || (rd_entry.stamp < old_stamp));
    slot     = hit ? hit_idx : (free_seen ? free_idx : old_idx);
  end

  // Next state and handshake outputs
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    rd_en      = 1'b0;
    ram_we     = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        rd_en = (issue_cnt != CNT_W'(ENTRIES));
        if (!rd_en && !rd_pend) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (req_action) begin
          ram_we     = 1'b1;
          state_next = S_IDLE;
        end else begin
          res_valid = 1'b1;
          if (res_ready) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign accept    = in_valid && in_ready;
  assign ram_re    = rd_en;
  assign ram_raddr = issue_cnt[IDX_W-1:0];
  assign ram_waddr = slot;

  always_comb begin
    wr_entry.key   = req_key;
    wr_entry.hw    = req_hw;
    wr_entry.stamp = req_now;
  end
  assign ram_wdata = wr_entry;

  always_comb begin
    res.found = hit;
    res.hw    = hit ? hit_hw : '0;
  end

  // Control state: advance the scan, track best candidates
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      valid     <= '0;
      issue_cnt <= '0;
      rd_pend   <= 1'b0;
      hit       <= 1'b0;
      free_seen <= 1'b0;
      old_seen  <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_en;
      if (ram_we) begin
        valid[slot] <= 1'b1;
      end
      if (accept) begin
        issue_cnt <= '0;
        hit       <= 1'b0;
        free_seen <= 1'b0;
        old_seen  <= 1'b0;
      end else begin
        if (rd_en) begin
          issue_cnt <= issue_cnt + CNT_W'(1);
        end
        if (rd_pend) begin
          if (rd_match && !hit) begin
            hit <= 1'b1;
          end
          if (!rd_valid && !free_seen) begin
            free_seen <= 1'b1;
          end
          if (rd_older) begin
            old_seen <= 1'b1;
          end
        end
      end
    end
  end

  // Payload: hold the request, record candidate indexes
  always_ff @(posedge clk) begin
    if (accept) begin
      req_action <= action;
      req_key    <= proto_addr;
      req_hw     <= new_hw_addr;
      req_now    <= now;
    end
    if (rd_en) begin
      rd_idx <= issue_cnt[IDX_W-1:0];
    end
    if (rd_pend) begin
      if (rd_match && !hit) begin
        hit_idx <= rd_idx;
        hit_hw  <= rd_entry.hw;
      end
      if (!rd_valid && !free_seen) begin
        free_idx <= rd_idx;
      end
      if (rd_older) begin
        old_idx   <= rd_idx;
        old_stamp <= rd_entry.stamp;
      end
    end
  end

endmodule
`default_nettype wire

/* sv/address_cache_oldest_replace.sv */
// A request is accepted only while the scanner is idle. The scanner then reads every
//   entry from memory, drains the last read, writes back a store or hands a lookup
//   result to the output register (waiting while it is full), and returns to idle
//   before it accepts the next request.
// A finished lookup waits in the output register while the next request scans.
// Reset: synchronous, clears the entry valid bits, the scanner control state and out_valid.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module address_cache_oldest_replace (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          action,
  input  wire logic [acor_pkg::KEY_W-1:0]    proto_addr,
  input  wire logic [acor_pkg::HW_W-1:0]     new_hw_addr,
  input  wire logic [acor_pkg::STAMP_W-1:0]  now,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               found,
  output logic      [acor_pkg::HW_W-1:0]     found_hw_addr
);

  import acor_pkg::*;

  logic               res_valid;
  logic               res_ready;
  res_t               res;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  acor_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .proto_addr (proto_addr),
    .new_hw_addr(new_hw_addr),
    .now        (now),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  acor_ram #(
    .DEPTH(ENTRIES),
    .WIDTH(ENTRY_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Output register: load when empty or being drained
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      found         <= res.found;
      found_hw_addr <= res.hw;
    end
  end

  // An accepted request occupies the scanner, so in_ready falls after the accept
  `ASSERT_PROP(a_busy_after_accept, clk, rst, (in_valid && in_ready) |=> !in_ready)
  // A miss never carries a hardware address
  `ASSERT_NEVER(a_miss_zero, clk, rst, out_valid && !found && (found_hw_addr != '0))
  // The scanner never offers a result while it can take a request
  `ASSERT_NEVER(a_res_while_idle, clk, rst, res_valid && in_ready)
  // A waiting result is not replaced before it is taken
  `ASSERT_PROP(a_hold_result, clk, rst,
               (out_valid && !out_ready) |=> (out_valid && $stable(found_hw_addr)))

endmodule
`default_nettype wire

/* sim/address_cache_oldest_replace_test.sv */
`timescale 1ns / 1ps
module address_cache_oldest_replace_test;
  import acor_pkg::*;

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_STORE  = 1'b1;

  localparam int DIR_ROWS     = 26;
  localparam int PHASE_REQS   = 342;
  localparam int KEY_POOL     = 24;
  localparam int HOLD_CYCLES  = 300;
  localparam int WATCH_LIMIT  = 3000;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic               action;
  logic [KEY_W-1:0]   proto_addr;
  logic [HW_W-1:0]    new_hw_addr;
  logic [STAMP_W-1:0] now;
  logic               out_valid;
  logic               out_ready;
  logic               found;
  logic [HW_W-1:0]    found_hw_addr;

  address_cache_oldest_replace dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .proto_addr    (proto_addr),
    .new_hw_addr   (new_hw_addr),
    .now           (now),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .found         (found),
    .found_hw_addr (found_hw_addr)
  );

  always #5 clk = ~clk;

  // One row of the directed request table
  typedef struct packed {
    logic               act;
    logic [KEY_W-1:0]   key;
    logic [HW_W-1:0]    hw;
    logic [STAMP_W-1:0] stamp;
    logic               typed;
    logic               exp_found;
    logic [HW_W-1:0]    exp_hw;
  } req_row_t;

  // Shadow copy of the address table
  bit                 map_valid [ENTRIES];
  logic [KEY_W-1:0]   map_key   [ENTRIES];
  logic [HW_W-1:0]    map_hw    [ENTRIES];
  logic [STAMP_W-1:0] map_stamp [ENTRIES];

  res_t lookup_results_q [$];

  int          error_cnt = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int unsigned hold_asks = 0;
  int unsigned hold_seen;
  int          hold_left;
  int          quiet_cycles = 0;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    error_cnt++;
  endtask

  // Index of the first valid entry holding key, ENTRIES when absent
  function automatic int match_index(input logic [KEY_W-1:0] key);
    for (int i = 0; i < ENTRIES; i++)
      if (map_valid[i] && map_key[i] == key) return i;
    return ENTRIES;
  endfunction

  function automatic res_t cache_lookup(input logic [KEY_W-1:0] key);
    res_t r;
    int   idx;
    idx = match_index(key);
    r.found = (idx < ENTRIES);
    r.hw    = (idx < ENTRIES) ? map_hw[idx] : '0;
    return r;
  endfunction

  // Refresh a match, else fill the lowest free slot, else evict the oldest stamp
  function automatic void cache_store(input logic [KEY_W-1:0] key, input logic [HW_W-1:0] hw,
                                      input logic [STAMP_W-1:0] stamp);
    int slot;
    slot = match_index(key);
    if (slot == ENTRIES) begin
      for (int i = ENTRIES - 1; i >= 0; i--)
        if (!map_valid[i]) slot = i;
    end
    if (slot == ENTRIES) begin
      slot = 0;
      for (int i = 1; i < ENTRIES; i++)
        if (map_stamp[i] < map_stamp[slot]) slot = i;
    end
    map_valid[slot] = 1'b1;
    map_key[slot]   = key;
    map_hw[slot]    = hw;
    map_stamp[slot] = stamp;
  endfunction

  // Offer one request, hold it until accepted, then update the shadow table or queue the expected result
  task automatic send_request(input logic act, input logic [KEY_W-1:0] key,
                              input logic [HW_W-1:0] hw, input logic [STAMP_W-1:0] stamp,
                              input logic typed, input res_t typed_res);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    proto_addr  <= key;
    new_hw_addr <= hw;
    now         <= stamp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (act == ACT_STORE)
      cache_store(key, hw, stamp);
    else if (typed)
      lookup_results_q.push_back(typed_res);
    else
      lookup_results_q.push_back(cache_lookup(key));
  endtask

  task automatic check_lookup_result();
    res_t exp_res;
    if (lookup_results_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result found=%0b hw=%h", found, found_hw_addr));
      return;
    end
    exp_res = lookup_results_q.pop_front();
    if (found !== exp_res.found)
      report_mismatch($sformatf("found %0b, expected %0b", found, exp_res.found));
    if (found_hw_addr !== exp_res.hw)
      report_mismatch($sformatf("found_hw_addr %h, expected %h", found_hw_addr, exp_res.hw));
  endtask

  // Drain results; stall at random or for a long hold when asked
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_seen <= 0;
      hold_left <= 0;
    end else begin
      if (out_valid && out_ready) check_lookup_result();
      if (hold_seen != hold_asks) begin
        hold_seen <= hold_asks;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("watchdog expired at %0t ns", $time);
      $display("simulation failed");
      $finish;
    end
  end

  // Random traffic over a small key pool so hits, refreshes and evictions all occur
  task automatic random_requests(input int n, ref logic [KEY_W-1:0] key_pool [KEY_POOL],
                                 ref logic [STAMP_W-1:0] tick);
    logic               act;
    logic [KEY_W-1:0]   key;
    logic [63:0]        r64;
    int                 pick;
    res_t               none;
    none = '0;
    for (int i = 0; i < n; i++) begin
      act = ($urandom_range(99) < 40) ? ACT_STORE : ACT_LOOKUP;
      key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(KEY_POOL - 1)] : $urandom();
      r64 = {$urandom(), $urandom()};
      pick = $urandom_range(99);
      // advance, repeat, jump anywhere, or fall back to a very old stamp
      if (pick < 70)
        tick = tick + $urandom_range(1, 50);
      else if (pick < 90)
        tick = {$urandom(), $urandom()};
      else if (pick < 95)
        tick = $urandom_range(0, 20);
      send_request(act, key, r64[HW_W-1:0], tick, 1'b0, none);
    end
  endtask

  initial begin
    req_row_t           dir_rows [DIR_ROWS];
    logic [KEY_W-1:0]   key_pool [KEY_POOL];
    logic [STAMP_W-1:0] tick;
    res_t               typed_res;

    rst         = 1'b1;
    in_valid    = 1'b0;
    action      = ACT_LOOKUP;
    proto_addr  = '0;
    new_hw_addr = '0;
    now         = '0;

    dir_rows = '{
      '{ACT_LOOKUP, 32'h0,         48'h0,              64'h0,  1'b1, 1'b0, 48'h0},
      '{ACT_LOOKUP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, '1,     1'b1, 1'b0, 48'h0},
      '{ACT_STORE,  32'h0,         48'h0,              64'h0,  1'b0, 1'b0, 48'h0},
      '{ACT_STORE,  32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, '1,     1'b0, 1'b0, 48'h0},
      '{ACT_LOOKUP, 32'h0,         48'h0,              64'h0,  1'b1, 1'b1, 48'h0},
      '{ACT_LOOKUP, 32'hFFFF_FFFF, 48'h0,              64'h0,  1'b1, 1'b1, 48'hFFFF_FFFF_FFFF},
      '{ACT_STORE,  32'h0,         48'hA5A5_5A5A_0F0F, 64'd40, 1'b0, 1'b0, 48'h0},
      '{ACT_LOOKUP, 32'h0,         48'h0,              64'h0,  1'b0, 1'b0, 48'h0},
      // fill the table; keys 5 and 9 share the smallest stamp
      '{ACT_STORE,  32'd1,  48'h0000_0000_0101, 64'd11, 1'b0, 1'b0, 48'h0},
      '{ACT_STORE,  32'd2,  48'h0000_0000_0202, 64'd12, 1'b0, 1'b0, 48'h0},
      '{ACT_STORE,  32'd3,  48'h0000_0000_0303, 64'd13, 1'b0, 1'b0, 48'h0},
      '{ACT_STORE,  32'd4,  48'h0000_0000_0404, 64'd14, 1'b0, 1'b0, 48'h0},
      '{ACT_STORE,  32'd5,  48'h0000_0000_0505, 64'd3,  1'b0, 1'b0, 48'h0},
      '{ACT_STORE,  32'd6,  48'h0000_0000_0606, 64'd16, 1'b0, 1'b0, 48'h0},
      '{ACT_STORE,  32'd7,  48'h0000_0000_0707, 64'd17, 1'b0, 1'b0, 48'h0},
      '{ACT_STORE,  32'd8,  48'h0000_0000_0808, 64'd18, 1'b0, 1'b0, 48'h0},
      '{ACT_STORE,  32'd9,  48'h0000_0000_0909, 64'd3,  1'b0, 1'b0, 48'h0},
      '{ACT_STORE,  32'd10, 48'h0000_0000_0A0A, 64'd20, 1'b0, 1'b0, 48'h0},
      '{ACT_STORE,  32'd11, 48'h0000_0000_0B0B, 64'd21, 1'b0, 1'b0, 48'h0},
      '{ACT_STORE,  32'd12, 48'h0000_0000_0C0C, 64'd22, 1'b0, 1'b0, 48'h0},
      '{ACT_STORE,  32'd13, 48'h0000_0000_0D0D, 64'd23, 1'b0, 1'b0, 48'h0},
      '{ACT_STORE,  32'd14, 48'h0000_0000_0E0E, 64'd24, 1'b0, 1'b0, 48'h0},
      // table full: evict the lower of the two oldest
      '{ACT_STORE,  32'h8000_0000, 48'h8000_0000_0001, 64'd100, 1'b0, 1'b0, 48'h0},
      '{ACT_LOOKUP, 32'd5,         48'h0, 64'h0, 1'b0, 1'b0, 48'h0},
      '{ACT_LOOKUP, 32'd9,         48'h0, 64'h0, 1'b0, 1'b0, 48'h0},
      '{ACT_LOOKUP, 32'h8000_0000, 48'h0, 64'h0, 1'b0, 1'b0, 48'h0}
    };

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom();
    tick = 64'd1000;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table, light sender gaps and heavy receiver stalls
    send_idle_pct = 9;
    recv_idle_pct = 81;
    for (int i = 0; i < DIR_ROWS; i++) begin
      typed_res.found = dir_rows[i].exp_found;
      typed_res.hw    = dir_rows[i].exp_hw;
      send_request(dir_rows[i].act, dir_rows[i].key, dir_rows[i].hw, dir_rows[i].stamp,
                   dir_rows[i].typed, typed_res);
    end
    random_requests(PHASE_REQS, key_pool, tick);

    // Pause the sender until every lookup has come back
    in_valid <= 1'b0;
    while (lookup_results_q.size() != 0) @(posedge clk);
    @(posedge clk);

    send_idle_pct = 81;
    recv_idle_pct = 9;
    random_requests(PHASE_REQS, key_pool, tick);

    // No idling; open with a long receiver hold so the input backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_asks++;
    random_requests(PHASE_REQS, key_pool, tick);

    in_valid <= 1'b0;
    while (lookup_results_q.size() != 0) @(posedge clk);
    repeat (ENTRIES + 8) @(posedge clk);
    if (lookup_results_q.size() != 0)
      report_mismatch($sformatf("%0d lookups never answered", lookup_results_q.size()));
    if (error_cnt == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/acor_pkg.sv
sv/acor_ram.sv
sv/acor_scan.sv
sv/address_cache_oldest_replace.sv
sim/address_cache_oldest_replace_test.sv
